>>> hw/rtl/l2sr_pkg.sv
`default_nettype none
package l2sr_pkg;

   localparam logic [7:0] CODE_CONN_REQ = 8'h02;
   localparam logic [7:0] CODE_CONN_RSP = 8'h03;
   localparam logic [7:0] CODE_CONF_REQ = 8'h04;
   localparam logic [7:0] CODE_CONF_RSP = 8'h05;
   localparam logic [7:0] CODE_DISC_REQ = 8'h06;
   localparam logic [7:0] CODE_DISC_RSP = 8'h07;
   localparam logic [7:0] CODE_INFO_REQ = 8'h0A;
   localparam logic [7:0] CODE_INFO_RSP = 8'h0B;

   localparam logic [15:0] RES_SUCCESS   = 16'h0000;
   localparam logic [15:0] RES_NO_PSM    = 16'h0002;
   localparam logic [15:0] INFO_NOT_SUPP = 16'h0001;

   localparam logic [3:0] LEN_CONN     = 4'd8;
   localparam logic [3:0] LEN_CONF_RSP = 4'd10;
   localparam logic [3:0] LEN_CONF_REQ = 4'd8;
   localparam logic [3:0] LEN_DISC     = 4'd4;
   localparam logic [3:0] LEN_INFO     = 4'd4;

   localparam logic [15:0] SERVED_PSM_RESET = 16'h1001;
   localparam logic [15:0] LOCAL_MTU_RESET  = 16'd672;

   localparam int          ADDR_W       = 3;
   localparam logic [0:0]  REG_SERVED_PSM = 1'b0;
   localparam logic [0:0]  REG_LOCAL_MTU  = 1'b1;

endpackage
`default_nettype wire

>>> hw/rtl/l2cap_signaling_responder.sv
// L2CAP signaling responder: each transaction on the req_ channel carries one complete
// signaling command and yields zero, one or two reply transactions on the rsp_ channel
// (two for a configure request, none for unknown codes). A command enters an input
// register and is turned into its replies by the logic in front of a single result
// register, which holds one reply at a time. A new command is accepted once the previous
// one has loaded its last reply or has been found to have none; the input register holds
// a configure request until its second reply has been loaded. served_psm sits at byte
// address 0 and local_mtu at byte address 4 of the APB-style port.
`default_nettype none
module l2cap_signaling_responder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_cmd_code,
   input  wire logic [7:0]  req_cmd_ident,
   input  wire logic [15:0] req_word_a,
   input  wire logic [15:0] req_word_b,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_resp_code,
   output logic [7:0]       rsp_resp_ident,
   output logic [3:0]       rsp_data_length,
   output logic [15:0]      rsp_word0,
   output logic [15:0]      rsp_word1,
   output logic [15:0]      rsp_word2,
   output logic [15:0]      rsp_word3,
   output logic             rsp_mtu_option,
   output logic [15:0]      rsp_mtu_value,
   output logic [15:0]      rsp_port_channel,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [l2sr_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [15:0] served_psm_ff;
   logic [15:0] local_mtu_ff;
   logic [15:0] port_channel_ff, port_channel_in;

   logic        in_valid_ff, in_valid_in;
   logic        phase_ff, phase_in;
   logic [7:0]  code_ff, ident_ff;
   logic [15:0] wa_ff, wb_ff;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_code_ff, out_code_in;
   logic [3:0]  out_len_ff, out_len_in;
   logic [15:0] out_w0_ff, out_w0_in;
   logic [15:0] out_w1_ff, out_w1_in;
   logic [15:0] out_w2_ff, out_w2_in;
   logic        out_opt_ff, out_opt_in;
   logic        out_last_ff, out_last_in;
   logic [7:0]  out_ident_ff;
   logic [15:0] out_pc_ff;

   logic out_free, has_result, two_results, emit, stage_done, req_take, psm_hit;

   // configuration port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         served_psm_ff <= l2sr_pkg::SERVED_PSM_RESET;
         local_mtu_ff  <= l2sr_pkg::LOCAL_MTU_RESET;
      end else if (psel && penable && pwrite) begin
         if (paddr[2] == l2sr_pkg::REG_SERVED_PSM) begin
            served_psm_ff <= pwdata[15:0];
         end else begin
            local_mtu_ff <= pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == l2sr_pkg::REG_LOCAL_MTU) begin
         prdata = {16'd0, local_mtu_ff};
      end else begin
         prdata = {16'd0, served_psm_ff};
      end
   end

   // command decode
   always_comb begin
      has_result  = 1'b0;
      two_results = 1'b0;
      unique case (code_ff) inside
         l2sr_pkg::CODE_CONN_REQ, l2sr_pkg::CODE_DISC_REQ, l2sr_pkg::CODE_INFO_REQ: begin
            has_result = 1'b1;
         end
         l2sr_pkg::CODE_CONF_REQ: begin
            has_result  = 1'b1;
            two_results = 1'b1;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign emit       = in_valid_ff && has_result && out_free;
   assign stage_done = in_valid_ff && (!has_result || (out_free && (!two_results || phase_ff)));
   assign req_stall  = in_valid_ff && !stage_done;
   assign req_take   = req_valid && !req_stall;
   assign psm_hit    = (wa_ff == served_psm_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      phase_in    = phase_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         phase_in    = 1'b0;
      end else if (stage_done) begin
         in_valid_in = 1'b0;
         phase_in    = 1'b0;
      end else if (emit) begin
         phase_in = 1'b1;
      end
   end

   always_comb begin
      port_channel_in = port_channel_ff;
      if (emit && (code_ff == l2sr_pkg::CODE_CONN_REQ) && psm_hit) begin
         port_channel_in = wb_ff;
      end
   end

   // reply build
   always_comb begin
      out_code_in = l2sr_pkg::CODE_INFO_RSP;
      out_len_in  = l2sr_pkg::LEN_INFO;
      out_w0_in   = wa_ff;
      out_w1_in   = 16'd0;
      out_w2_in   = 16'd0;
      out_opt_in  = 1'b0;
      out_last_in = 1'b1;
      case (code_ff)
         l2sr_pkg::CODE_CONN_REQ: begin
            out_code_in = l2sr_pkg::CODE_CONN_RSP;
            out_len_in  = l2sr_pkg::LEN_CONN;
            out_w0_in   = wb_ff;
            out_w1_in   = wb_ff;
            out_w2_in   = psm_hit ? l2sr_pkg::RES_SUCCESS : l2sr_pkg::RES_NO_PSM;
         end
         l2sr_pkg::CODE_CONF_REQ: begin
            out_opt_in = 1'b1;
            if (phase_ff) begin
               out_code_in = l2sr_pkg::CODE_CONF_REQ;
               out_len_in  = l2sr_pkg::LEN_CONF_REQ;
            end else begin
               out_code_in = l2sr_pkg::CODE_CONF_RSP;
               out_len_in  = l2sr_pkg::LEN_CONF_RSP;
               out_last_in = 1'b0;
            end
         end
         l2sr_pkg::CODE_DISC_REQ: begin
            out_code_in = l2sr_pkg::CODE_DISC_RSP;
            out_len_in  = l2sr_pkg::LEN_DISC;
            out_w1_in   = wb_ff;
         end
         default: begin
            out_w1_in = l2sr_pkg::INFO_NOT_SUPP;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         phase_ff        <= 1'b0;
         out_valid_ff    <= 1'b0;
         port_channel_ff <= 16'd0;
      end else begin
         in_valid_ff     <= in_valid_in;
         phase_ff        <= phase_in;
         out_valid_ff    <= out_valid_in;
         port_channel_ff <= port_channel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         code_ff  <= req_cmd_code;
         ident_ff <= req_cmd_ident;
         wa_ff    <= req_word_a;
         wb_ff    <= req_word_b;
      end
      if (emit) begin
         out_code_ff  <= out_code_in;
         out_ident_ff <= ident_ff;
         out_len_ff   <= out_len_in;
         out_w0_ff    <= out_w0_in;
         out_w1_ff    <= out_w1_in;
         out_w2_ff    <= out_w2_in;
         out_opt_ff   <= out_opt_in;
         out_last_ff  <= out_last_in;
         out_pc_ff    <= port_channel_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_resp_code    = out_code_ff;
   assign rsp_resp_ident   = out_ident_ff;
   assign rsp_data_length  = out_len_ff;
   assign rsp_word0        = out_w0_ff;
   assign rsp_word1        = out_w1_ff;
   assign rsp_word2        = out_w2_ff;
   assign rsp_word3        = 16'd0;
   assign rsp_mtu_option   = out_opt_ff;
   assign rsp_mtu_value    = out_opt_ff ? local_mtu_ff : 16'd0;
   assign rsp_port_channel = out_pc_ff;
   assign rsp_last         = out_last_ff;

endmodule
`default_nettype wire

>>> hw/rtl/l2sr_checker.sv
`default_nettype none
module l2sr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_resp_code,
   input wire logic [7:0]  rsp_resp_ident,
   input wire logic [3:0]  rsp_data_length,
   input wire logic        rsp_mtu_option,
   input wire logic [15:0] rsp_mtu_value,
   input wire logic        rsp_last
);

   // a stalled result transaction stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // only the configure response is followed by another reply
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_resp_code == l2sr_pkg::CODE_CONF_RSP
         && rsp_data_length == l2sr_pkg::LEN_CONF_RSP)
      else $error("non-final reply is not a configure response");

   // configure request follows its response at once with the same identifier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_last
         && rsp_resp_code == l2sr_pkg::CODE_CONF_REQ
         && rsp_resp_ident == $past(rsp_resp_ident))
      else $error("configure request missing after configure response");

   // mtu value is zero without the option
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mtu_option |-> rsp_mtu_value == 16'd0)
      else $error("mtu value set without mtu option");

endmodule

bind l2cap_signaling_responder l2sr_checker u_l2sr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_resp_code   (rsp_resp_code),
   .rsp_resp_ident  (rsp_resp_ident),
   .rsp_data_length (rsp_data_length),
   .rsp_mtu_option  (rsp_mtu_option),
   .rsp_mtu_value   (rsp_mtu_value),
   .rsp_last        (rsp_last)
);
`default_nettype wire
